[rtl/tls_pkg.sv]
// Package for the two-way traffic light sequencer.
// Holds the phase codes, the lamp table, the config and state structs.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package tls_pkg;

  // Width of the per-phase tick counter.
  localparam int TIMER_BITS = 16;
  localparam int DUR_BITS   = 16;
  localparam int FLASH_BITS = 4;
  localparam int LAMP_BITS  = 6;
  localparam int PHASE_BITS = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_GREEN      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_YELLOW     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OVERLAP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLASH_CYC  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLASH_HALF = 3'd4;

  // Sequencer phases, numbered as the phase_code output.
  typedef enum logic [PHASE_BITS-1:0] {
    PH_FLASH_ON  = 4'd0,
    PH_FLASH_OFF = 4'd1,
    PH_G1R2      = 4'd2,
    PH_Y1R2      = 4'd3,
    PH_R1R2Y2    = 4'd4,
    PH_R1G2      = 4'd5,
    PH_R1Y2      = 4'd6,
    PH_R1R2Y1    = 4'd7,
    PH_STOPPED   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [DUR_BITS-1:0]   green_ticks;
    logic [DUR_BITS-1:0]   yellow_ticks;
    logic [DUR_BITS-1:0]   overlap_ticks;
    logic [FLASH_BITS-1:0] flash_cycles;
    logic [DUR_BITS-1:0]   flash_half_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [TIMER_BITS-1:0] tick_count;
    logic [FLASH_BITS-1:0] flash_count;
    logic                  stop_latched;
  } seq_state_t;

  // Lamp pattern of each phase; bit 0 red_one up to bit 5 green_two.
  function automatic logic [LAMP_BITS-1:0] tls_lamps(input phase_t ph);
    logic [LAMP_BITS-1:0] l;
    case (ph)
      PH_FLASH_ON:  l = 6'h3F;
      PH_FLASH_OFF: l = 6'h00;
      PH_G1R2:      l = 6'h0C;
      PH_Y1R2:      l = 6'h0A;
      PH_R1R2Y2:    l = 6'h19;
      PH_R1G2:      l = 6'h21;
      PH_R1Y2:      l = 6'h11;
      PH_R1R2Y1:    l = 6'h0B;
      default:      l = 6'h0C;
    endcase
    return l;
  endfunction

  // Duration of a phase in ticks; zero counts as one.
  function automatic logic [TIMER_BITS-1:0] tls_length(input phase_t ph, input cfg_t c);
    logic [DUR_BITS-1:0] d;
    case (ph)
      PH_FLASH_ON, PH_FLASH_OFF: d = c.flash_half_ticks;
      PH_G1R2, PH_R1G2:          d = c.green_ticks;
      PH_Y1R2, PH_R1Y2:          d = c.yellow_ticks;
      default:                   d = c.overlap_ticks;
    endcase
    if (d == '0) begin
      d = DUR_BITS'(1);
    end
    return TIMER_BITS'(d);
  endfunction

endpackage

[rtl/tls_config.sv]
// Configuration register file of the traffic light sequencer.
// Depends on tls_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module tls_config (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tls_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output tls_pkg::cfg_t                      cfg
);
  import tls_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_ticks      <= 16'd600;
      cfg.yellow_ticks     <= 16'd50;
      cfg.overlap_ticks    <= 16'd20;
      cfg.flash_cycles     <= 4'd5;
      cfg.flash_half_ticks <= 16'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GREEN:      cfg.green_ticks      <= cfg_data[DUR_BITS-1:0];
        REG_YELLOW:     cfg.yellow_ticks     <= cfg_data[DUR_BITS-1:0];
        REG_OVERLAP:    cfg.overlap_ticks    <= cfg_data[DUR_BITS-1:0];
        REG_FLASH_CYC:  cfg.flash_cycles     <= cfg_data[FLASH_BITS-1:0];
        REG_FLASH_HALF: cfg.flash_half_ticks <= cfg_data[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/tls_step.sv]
// Next-state logic of the traffic light sequencer for one input beat.
// Depends on tls_pkg for phases, lamp and duration functions and structs.
`timescale 1ns / 1ps

module tls_step (
  input  tls_pkg::seq_state_t state,
  input  tls_pkg::cfg_t       cfg,
  input  logic                tick,
  input  logic                stop_request,
  output tls_pkg::seq_state_t state_next
);
  import tls_pkg::*;

  phase_t                ph;
  logic [TIMER_BITS-1:0] cnt;
  logic [FLASH_BITS-1:0] fc;
  logic [FLASH_BITS-1:0] fc_inc;
  logic                  stop_n;
  logic                  expire;

  always_comb begin
    stop_n = state.stop_latched | stop_request;
    ph     = state.phase;
    cnt    = state.tick_count;
    fc     = state.flash_count;
    fc_inc = state.flash_count + FLASH_BITS'(1);

    // A code past the stopped one falls into the stopped phase.
    if (ph > PH_STOPPED) begin
      ph  = PH_STOPPED;
      cnt = '0;
    end

    // Flash already complete (for instance zero flashes configured).
    if (ph == PH_FLASH_ON && fc >= cfg.flash_cycles) begin
      ph  = stop_n ? PH_STOPPED : PH_G1R2;
      cnt = '0;
    end

    expire = ({1'b0, cnt} + (TIMER_BITS+1)'(1)) >= {1'b0, tls_length(ph, cfg)};

    // Count the tick or move to the next phase.
    if (tick && ph != PH_STOPPED) begin
      if (expire) begin
        cnt = '0;
        case (ph)
          PH_FLASH_ON:  ph = PH_FLASH_OFF;
          PH_FLASH_OFF: begin
            fc = fc_inc;
            if (fc_inc == '0 || fc_inc >= cfg.flash_cycles) begin
              ph = stop_n ? PH_STOPPED : PH_G1R2;
            end else begin
              ph = PH_FLASH_ON;
            end
          end
          PH_R1R2Y1:    ph = stop_n ? PH_STOPPED : PH_G1R2;
          default:      ph = phase_t'(ph + PHASE_BITS'(1));
        endcase
      end else begin
        cnt = cnt + TIMER_BITS'(1);
      end
    end

    state_next.phase        = ph;
    state_next.tick_count   = cnt;
    state_next.flash_count  = fc;
    state_next.stop_latched = stop_n;
  end

endmodule

[rtl/two_way_traffic_light_sequencer_core.sv]
// Top level of the two-way traffic light sequencer.
// Depends on tls_pkg, tls_config and tls_step.
`timescale 1ns / 1ps

// Unless the output stalls, the block takes one beat per clock (a tick
// flag and a stop request) and returns one beat per input with the six
// lamps and the phase code after that step, so throughput is one beat per
// cycle, set by the combinational phase and tick counter update; a beat
// passes the input, then the result register. After reset the lamps flash, then the
// six traffic phases repeat; a latched stop ends the flash or a full cycle
// and holds green on head one with red on head two until reset.
// Configuration registers may be written while no beat is in flight.
module two_way_traffic_light_sequencer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // tick, stop_request, zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // red_one, yellow_one, green_one,
                                                       // red_two, yellow_two, green_two,
                                                       // phase_code[3:0], zero pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tls_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tls_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  logic       in_valid;
  logic       in_tick;
  logic       in_stop;
  logic       advance;

  tls_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tls_step u_step (
    .state        (state),
    .cfg          (cfg),
    .tick         (in_tick),
    .stop_request (in_stop),
    .state_next   (state_next)
  );

  // The held beat moves on when the result register is free or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_tick <= s_tdata[0];
      in_stop <= s_tdata[1];
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_FLASH_ON;
      state.tick_count   <= '0;
      state.flash_count  <= '0;
      state.stop_latched <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'b0, state_next.phase, tls_lamps(state_next.phase)};
    end
  end

`ifndef SYNTHESIS
  // The stopped phase is terminal.
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_STOPPED |=> state.phase == PH_STOPPED)
    else $error("sequencer left the stopped phase");

  // A latched stop request is never forgotten.
  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    state.stop_latched |=> state.stop_latched)
    else $error("stop latch cleared");

  // A result beat shows the lamps of its own phase.
  a_lamps_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[5:0] == tls_lamps(phase_t'(m_tdata[9:6])))
    else $error("lamps do not match phase code");

  // A held beat that cannot move stays in the input register.
  a_in_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_tick) && $stable(in_stop))
    else $error("stalled input beat lost");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for two_way_traffic_light_sequencer_core.
// Drives tick/stop beats, predicts lamps and phase per beat, checks results in order.
// Depends on tls_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module testbench;
  import tls_pkg::*;

  // Expected lamps and phase after one input beat.
  typedef struct packed {
    phase_t               phase;
    logic [LAMP_BITS-1:0] lamps;
  } light_state_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_FIRST = REG_FLASH_HALF + 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LAST  = {CFG_IDX_BITS{1'b1}};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = 8'd0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [15:0]              m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Beats waiting for the driver: bit 0 tick, bit 1 stop request.
  logic [1:0]   beat_queue[$];
  light_state_t lamp_expect[$];
  int           beats_queued = 0;
  int           beats_taken = 0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         in_fire = 1'b0;
  string        lamp_names[LAMP_BITS] = '{"red_one", "yellow_one", "green_one",
                                          "red_two", "yellow_two", "green_two"};

  // Predictor copy of the configuration, at reset values.
  logic [DUR_BITS-1:0]   green_len = 16'd600;
  logic [DUR_BITS-1:0]   yellow_len = 16'd50;
  logic [DUR_BITS-1:0]   overlap_len = 16'd20;
  logic [FLASH_BITS-1:0] flash_total = 4'd5;
  logic [DUR_BITS-1:0]   flash_half_len = 16'd10;

  // Predictor copy of the sequencer state.
  phase_t                cur_phase = PH_FLASH_ON;
  logic [TIMER_BITS-1:0] ticks_in_phase = '0;
  logic [FLASH_BITS-1:0] flashes_done = '0;
  logic                  halt_pending = 1'b0;

  two_way_traffic_light_sequencer_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Lamp pattern shown in each phase, bit 0 red_one up to bit 5 green_two.
  function automatic logic [LAMP_BITS-1:0] lamps_of(input phase_t ph);
    case (ph)
      PH_FLASH_ON:  return 6'b111111;
      PH_FLASH_OFF: return 6'b000000;
      PH_G1R2:      return 6'b001100;
      PH_Y1R2:      return 6'b001010;
      PH_R1R2Y2:    return 6'b011001;
      PH_R1G2:      return 6'b100001;
      PH_R1Y2:      return 6'b010001;
      PH_R1R2Y1:    return 6'b001011;
      default:      return 6'b001100;
    endcase
  endfunction

  // Ticks a phase lasts; a zero setting counts as one tick.
  function automatic logic [TIMER_BITS:0] span_of(input phase_t ph);
    logic [DUR_BITS-1:0] d;
    case (ph)
      PH_FLASH_ON, PH_FLASH_OFF: d = flash_half_len;
      PH_G1R2, PH_R1G2:          d = green_len;
      PH_Y1R2, PH_R1Y2:          d = yellow_len;
      default:                   d = overlap_len;
    endcase
    return (d == '0) ? 17'd1 : {1'b0, d};
  endfunction

  // Advances the predicted sequencer by one beat and returns what it shows.
  function automatic light_state_t advance_lights(input logic tick, input logic stop);
    light_state_t r;
    if (stop) begin
      halt_pending = 1'b1;
    end
    // A flash with its count already reached ends before the tick counts.
    if (cur_phase == PH_FLASH_ON && flashes_done >= flash_total) begin
      cur_phase = halt_pending ? PH_STOPPED : PH_G1R2;
      ticks_in_phase = '0;
    end
    if (tick && cur_phase != PH_STOPPED) begin
      if ({1'b0, ticks_in_phase} + 17'd1 >= span_of(cur_phase)) begin
        ticks_in_phase = '0;
        case (cur_phase)
          PH_FLASH_ON: cur_phase = PH_FLASH_OFF;
          PH_FLASH_OFF: begin
            flashes_done = flashes_done + 4'd1;
            if (flashes_done == '0 || flashes_done >= flash_total) begin
              cur_phase = halt_pending ? PH_STOPPED : PH_G1R2;
            end else begin
              cur_phase = PH_FLASH_ON;
            end
          end
          PH_R1R2Y1: cur_phase = halt_pending ? PH_STOPPED : PH_G1R2;
          default: cur_phase = phase_t'(cur_phase + 4'd1);
        endcase
      end else begin
        ticks_in_phase = ticks_in_phase + 16'd1;
      end
    end
    r.phase = cur_phase;
    r.lamps = lamps_of(cur_phase);
    return r;
  endfunction

  // Sample accepted config writes, input beats and result beats at the rising edge.
  always @(posedge clk) begin : monitor
    light_state_t want;
    in_fire = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GREEN:      green_len = cfg_data;
          REG_YELLOW:     yellow_len = cfg_data;
          REG_OVERLAP:    overlap_len = cfg_data;
          REG_FLASH_CYC:  flash_total = cfg_data[FLASH_BITS-1:0];
          REG_FLASH_HALF: flash_half_len = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        in_fire = 1'b1;
        lamp_expect.push_back(advance_lights(s_tdata[0], s_tdata[1]));
        beats_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (lamp_expect.size() == 0) begin
          $error("result beat with no prediction waiting: %h", m_tdata);
          mismatches++;
        end else begin
          want = lamp_expect.pop_front();
          for (int i = 0; i < LAMP_BITS; i++) begin
            if (m_tdata[i] !== want.lamps[i]) begin
              $error("%s: expected %0b, got %0b", lamp_names[i], want.lamps[i], m_tdata[i]);
              mismatches++;
            end
          end
          if (m_tdata[9:6] !== want.phase) begin
            $error("phase_code: expected %0d, got %0d", want.phase, m_tdata[9:6]);
            mismatches++;
          end
          if (m_tdata[15:10] !== '0) begin
            $error("pad: expected 0, got %0h", m_tdata[15:10]);
            mismatches++;
          end
        end
      end
    end
  end

  // Present queued beats and randomize the receiver's ready at the falling edge.
  always @(negedge clk) begin
    if (!s_tvalid || in_fire) begin
      if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= {6'd0, beat_queue.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_beat(input logic tick, input logic stop);
    beat_queue.push_back({stop, tick});
    beats_queued++;
  endtask

  // Wait until every queued beat is in and every predicted result is out.
  task automatic settle();
    do @(negedge clk); while (beats_taken != beats_queued || lamp_expect.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short phases, now and then a zero or a very long one.
  function automatic logic [DUR_BITS-1:0] pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      return '0;
    end else if (r < 10) begin
      return DUR_BITS'($urandom_range(65535));
    end
    return DUR_BITS'($urandom_range(6, 1));
  endfunction

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 72;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short flash, then end it early by dropping the flash count to zero.
    program_reg(REG_FLASH_CYC, 16'd2);
    program_reg(REG_FLASH_HALF, 16'd1);
    program_reg(REG_GREEN, 16'd1);
    program_reg(REG_YELLOW, 16'd1);
    program_reg(REG_OVERLAP, 16'd1);
    queue_beat(1'b0, 1'b0);
    queue_beat(1'b1, 1'b0);
    queue_beat(1'b1, 1'b0);
    settle();
    program_reg(REG_FLASH_CYC, 16'd0);
    queue_beat(1'b0, 1'b0);
    // One-tick phases: walk the whole cycle and wrap.
    repeat (8) queue_beat(1'b1, 1'b0);
    queue_beat(1'b0, 1'b0);
    settle();

    // Zero green, longest yellow and overlap; the current phase holds.
    program_reg(REG_GREEN, 16'd0);
    program_reg(REG_YELLOW, 16'hFFFF);
    program_reg(REG_OVERLAP, 16'hFFFF);
    repeat (6) queue_beat(1'b1, 1'b0);
    settle();
    // Shortening a running phase ends it on the next tick.
    program_reg(REG_OVERLAP, 16'd1);
    program_reg(REG_FLASH_CYC, 16'd15);
    program_reg(REG_FLASH_HALF, 16'hFFFF);
    for (int i = int'(REG_UNUSED_FIRST); i <= int'(REG_UNUSED_LAST); i++) begin
      program_reg(CFG_IDX_BITS'(i), 16'hFFFF);
    end
    repeat (6) queue_beat(1'b1, 1'b0);

    // Random traffic in three idling regimes, settings changed every block.
    for (int seg = 0; seg < 3; seg++) begin
      for (int blk = 0; blk < 4; blk++) begin
        settle();
        send_idle_pct = (seg == 0) ? 22 : (seg == 1) ? 72 : 0;
        recv_idle_pct = (seg == 0) ? 72 : (seg == 1) ? 22 : 0;
        program_reg(REG_GREEN, pick_span());
        program_reg(REG_YELLOW, pick_span());
        program_reg(REG_OVERLAP, pick_span());
        program_reg(REG_FLASH_CYC, CFG_DATA_BITS'($urandom_range(15)));
        program_reg(REG_FLASH_HALF, CFG_DATA_BITS'($urandom_range(65535)));
        if ($urandom_range(1) == 1) begin
          program_reg(CFG_IDX_BITS'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                      CFG_DATA_BITS'($urandom_range(65535)));
        end
        repeat (65) queue_beat($urandom_range(99) < 75, 1'b0);
      end
    end

    // Stop requests: the cycle runs out, then the lamps hold for good.
    settle();
    program_reg(REG_GREEN, CFG_DATA_BITS'($urandom_range(4, 1)));
    program_reg(REG_YELLOW, CFG_DATA_BITS'($urandom_range(4, 1)));
    program_reg(REG_OVERLAP, CFG_DATA_BITS'($urandom_range(4, 1)));
    for (int i = 0; i < 40; i++) begin
      queue_beat(1'($urandom_range(1)), (i == 20) || ($urandom_range(5) == 0));
    end
    repeat (30) queue_beat(1'b1, 1'b0);
    repeat (20) queue_beat(1'($urandom_range(1)), 1'($urandom_range(1)));

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
